@@ hdl/ftws_pkg.sv @@
// shared types and constants for the frame time window statistics block
`default_nettype none
package ftws_pkg;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [27:0] US_PER_S_Q8 = 28'd256000000;
    localparam logic [27:0] FPS_MAX     = 28'hFFFFFFF;
    localparam logic [19:0] PFRAMES_MAX = 20'hFFFFF;
    localparam logic [51:0] PSUM_MAX    = 52'hFFFFFFFFFFFFF;

    localparam logic [31:0] PERIOD_RESET = 32'd1000000;

    localparam int          CFG_AW        = 3;
    localparam logic [2:0]  ADDR_ENABLE   = 3'd0;
    localparam logic [2:0]  ADDR_PERIOD   = 3'd4;

    typedef enum logic [1:0] {
        DIV_PFPS  = 2'd0,
        DIV_PMEAN = 2'd1,
        DIV_FPS   = 2'd2,
        DIV_MEAN  = 2'd3
    } ftws_div_sel_t;

    typedef struct packed {
        logic          load_item;
        logic          set_frame_start;
        logic          clear;
        logic          update;
        logic          mul;
        logic          period_reset;
        logic          div_start;
        ftws_div_sel_t div_sel;
        logic          cap_pfps;
        logic          cap_pmean;
        logic          cap_fps;
        logic          push;
        logic          scan_step;
        logic          cap_minmax;
        logic          cap_mean;
        logic          load_out;
    } ftws_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       enable;
        logic       period_hit;
        logic       frames_nz;
        logic       ft_nz;
        logic       scan_done;
        logic       div_done;
    } ftws_sts_t;

    typedef struct packed {
        logic [31:0] frame_time_us;
        logic [27:0] fps_q8;
        logic [31:0] window_min_us;
        logic [31:0] window_max_us;
        logic [31:0] window_mean_us;
        logic [27:0] period_fps_q8;
        logic [31:0] period_mean_us;
        logic [31:0] frame_total;
    } ftws_metrics_t;

endpackage
`default_nettype wire

@@ hdl/ftws_if.sv @@
// valid/ready channel interfaces for event beats and result beats
`default_nettype none
interface ftws_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] timestamp_us;

    modport source (output valid, output mode, output timestamp_us, input ready);
    modport sink (input valid, input mode, input timestamp_us, output ready);
endinterface

interface ftws_out_if #(parameter int FW = 7);
    logic          valid;
    logic          ready;
    logic [31:0]   frame_time_us;
    logic [27:0]   fps_q8;
    logic [31:0]   window_min_us;
    logic [31:0]   window_max_us;
    logic [31:0]   window_mean_us;
    logic [27:0]   period_fps_q8;
    logic [31:0]   period_mean_us;
    logic [31:0]   frame_total;
    logic [FW-1:0] window_fill;

    modport source (output valid, output frame_time_us, output fps_q8, output window_min_us,
                    output window_max_us, output window_mean_us, output period_fps_q8,
                    output period_mean_us, output frame_total, output window_fill,
                    input ready);
    modport sink (input valid, input frame_time_us, input fps_q8, input window_min_us,
                  input window_max_us, input window_mean_us, input period_fps_q8,
                  input period_mean_us, input frame_total, input window_fill,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/ftws_div.sv @@
// 64 by 32 bit restoring divider, one quotient bit per cycle
`default_nettype none
module ftws_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    logic [32:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = shifted - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

@@ hdl/ftws_datapath.sv @@
// datapath: event registers, period counters, window store, scan and divider
`default_nettype none
module ftws_datapath #(
    parameter int HISTORY_DEPTH = 64,
    parameter int FW = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ftws_pkg::ftws_cmd_t  cmd,
    output ftws_pkg::ftws_sts_t       sts,
    input  wire logic [1:0]           in_mode,
    input  wire logic [31:0]          in_timestamp_us,
    input  wire logic                 cfg_enable,
    input  wire logic [31:0]          cfg_period_us,
    output ftws_pkg::ftws_metrics_t   metrics,
    output logic [FW-1:0]             window_fill
);
    import ftws_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW = 32 + FW;
    localparam logic [FW-1:0] DEPTH_F = FW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

    logic [31:0]   mem [HISTORY_DEPTH];
    logic [31:0]   rdata_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [1:0]    mode_reg;
    logic [31:0]   ts_reg;
    logic [31:0]   frame_start_reg;
    logic [31:0]   period_start_reg;
    logic [31:0]   elapsed_reg;
    logic [19:0]   pframes_reg;
    logic [51:0]   psum_reg;
    logic [47:0]   prod_reg;
    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [SW-1:0] sum_reg;
    logic [FW-1:0] scan_idx_reg;
    logic          rd_pend_reg;
    logic          first_reg;
    logic [31:0]   lo_reg, hi_reg;
    ftws_metrics_t met_reg;

    logic [31:0]   ft_now;
    logic [52:0]   psum_add;
    logic [SW-1:0] sum_base;
    logic [63:0]   div_dividend;
    logic [31:0]   div_divisor;
    logic          div_done;
    logic [63:0]   div_q;

    assign ft_now   = ts_reg - frame_start_reg;
    assign psum_add = {1'b0, psum_reg} + 53'(ft_now);
    assign sum_base = (fill_reg == DEPTH_F) ? (sum_reg - SW'(rdata_reg)) : sum_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_PFPS:
            begin
                div_dividend = 64'(prod_reg);
                div_divisor  = elapsed_reg;
            end
            DIV_PMEAN:
            begin
                div_dividend = 64'(psum_reg);
                div_divisor  = 32'(pframes_reg);
            end
            DIV_FPS:
            begin
                div_dividend = 64'(US_PER_S_Q8);
                div_divisor  = met_reg.frame_time_us;
            end
            DIV_MEAN:
            begin
                div_dividend = 64'(sum_reg);
                div_divisor  = 32'(fill_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    ftws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // window store
    assign rd_en   = cmd.update || (cmd.scan_step && (scan_idx_reg != fill_reg));
    assign rd_addr = cmd.update ? head_reg : scan_idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[head_reg] <= met_reg.frame_time_us;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= in_mode;
            ts_reg   <= in_timestamp_us;
        end
        if (cmd.update)
        begin
            elapsed_reg <= ts_reg - period_start_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= 48'(pframes_reg) * 48'(US_PER_S_Q8);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg  <= '0;
            period_start_reg <= '0;
            pframes_reg      <= '0;
            psum_reg         <= '0;
            head_reg         <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            scan_idx_reg     <= '0;
            rd_pend_reg      <= 1'b0;
            first_reg        <= 1'b0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            met_reg          <= '0;
        end
        else
        begin
            if (cmd.set_frame_start)
            begin
                frame_start_reg <= ts_reg;
            end
            if (cmd.clear)
            begin
                met_reg  <= '0;
                head_reg <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            if (cmd.update)
            begin
                met_reg.frame_time_us <= ft_now;
                met_reg.frame_total   <= met_reg.frame_total + 32'd1;
                if (pframes_reg != PFRAMES_MAX)
                begin
                    pframes_reg <= pframes_reg + 20'd1;
                end
                psum_reg <= psum_add[52] ? PSUM_MAX : psum_add[51:0];
            end
            if (cmd.period_reset)
            begin
                pframes_reg      <= '0;
                psum_reg         <= '0;
                period_start_reg <= ts_reg;
            end
            if (cmd.cap_pfps)
            begin
                met_reg.period_fps_q8 <= (div_q > 64'(FPS_MAX)) ? FPS_MAX : div_q[27:0];
            end
            if (cmd.cap_pmean)
            begin
                met_reg.period_mean_us <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
            end
            if (cmd.cap_fps)
            begin
                met_reg.fps_q8 <= div_q[27:0];
            end
            if (cmd.push)
            begin
                sum_reg  <= sum_base + SW'(met_reg.frame_time_us);
                if (fill_reg != DEPTH_F)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
                head_reg     <= (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
                scan_idx_reg <= '0;
                rd_pend_reg  <= 1'b0;
                first_reg    <= 1'b1;
            end
            if (cmd.scan_step)
            begin
                if (scan_idx_reg != fill_reg)
                begin
                    scan_idx_reg <= scan_idx_reg + FW'(1);
                end
                rd_pend_reg <= (scan_idx_reg != fill_reg);
                if (rd_pend_reg)
                begin
                    first_reg <= 1'b0;
                    if (first_reg || (rdata_reg < lo_reg))
                    begin
                        lo_reg <= rdata_reg;
                    end
                    if (first_reg || (rdata_reg > hi_reg))
                    begin
                        hi_reg <= rdata_reg;
                    end
                end
            end
            if (cmd.cap_minmax)
            begin
                met_reg.window_min_us <= lo_reg;
                met_reg.window_max_us <= hi_reg;
            end
            if (cmd.cap_mean)
            begin
                met_reg.window_mean_us <= div_q[31:0];
            end
        end
    end

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.enable     = cfg_enable;
        sts.period_hit = (elapsed_reg >= cfg_period_us);
        sts.frames_nz  = (pframes_reg != '0);
        sts.ft_nz      = (met_reg.frame_time_us != '0);
        sts.scan_done  = (scan_idx_reg == fill_reg) && !rd_pend_reg;
        sts.div_done   = div_done;
    end

    assign metrics     = met_reg;
    assign window_fill = fill_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_F)
        else $error("window fill beyond depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (fill_reg == '0) && (sum_reg == '0))
        else $error("clear left window contents");

    a_mean_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_mean |-> (fill_reg != '0))
        else $error("window mean taken over empty window");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && (fill_reg != DEPTH_F)) |=> (fill_reg == $past(fill_reg) + FW'(1)))
        else $error("window fill did not grow on push");
endmodule
`default_nettype wire

@@ hdl/ftws_ctrl.sv @@
// controller state machine sequencing one event through the datapath
`default_nettype none
module ftws_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                out_free,
    input  wire ftws_pkg::ftws_sts_t sts,
    output ftws_pkg::ftws_cmd_t      cmd
);
    import ftws_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE       = 16'h0001,
        ST_EXEC       = 16'h0002,
        ST_UPD        = 16'h0004,
        ST_PER        = 16'h0008,
        ST_PFPS_GO    = 16'h0010,
        ST_PFPS_WAIT  = 16'h0020,
        ST_PMEAN_GO   = 16'h0040,
        ST_PMEAN_WAIT = 16'h0080,
        ST_FPS_CHK    = 16'h0100,
        ST_FPS_GO     = 16'h0200,
        ST_FPS_WAIT   = 16'h0400,
        ST_PUSH       = 16'h0800,
        ST_SCAN       = 16'h1000,
        ST_MEAN_GO    = 16'h2000,
        ST_MEAN_WAIT  = 16'h4000,
        ST_FINISH     = 16'h8000
    } ftws_state_t;

    ftws_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MEAN;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                if (sts.mode == MODE_BEGIN && sts.enable)
                begin
                    cmd.set_frame_start = 1'b1;
                end
                else if (sts.mode == MODE_END && sts.enable)
                begin
                    state_next = ST_UPD;
                end
                else if (sts.mode == MODE_CLEAR)
                begin
                    cmd.clear = 1'b1;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_PER;
            end
            ST_PER:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FPS_CHK;
                if (sts.period_hit)
                begin
                    if (sts.frames_nz)
                    begin
                        state_next = ST_PFPS_GO;
                    end
                    else
                    begin
                        cmd.period_reset = 1'b1;
                    end
                end
            end
            ST_PFPS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PFPS;
                state_next    = ST_PFPS_WAIT;
            end
            ST_PFPS_WAIT:
            begin
                cmd.div_sel = DIV_PFPS;
                if (sts.div_done)
                begin
                    cmd.cap_pfps = 1'b1;
                    state_next   = ST_PMEAN_GO;
                end
            end
            ST_PMEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PMEAN;
                state_next    = ST_PMEAN_WAIT;
            end
            ST_PMEAN_WAIT:
            begin
                cmd.div_sel = DIV_PMEAN;
                if (sts.div_done)
                begin
                    cmd.cap_pmean    = 1'b1;
                    cmd.period_reset = 1'b1;
                    state_next       = ST_FPS_CHK;
                end
            end
            ST_FPS_CHK:
            begin
                state_next = sts.ft_nz ? ST_FPS_GO : ST_PUSH;
            end
            ST_FPS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_FPS;
                state_next    = ST_FPS_WAIT;
            end
            ST_FPS_WAIT:
            begin
                cmd.div_sel = DIV_FPS;
                if (sts.div_done)
                begin
                    cmd.cap_fps = 1'b1;
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:
            begin
                cmd.div_start  = 1'b1;
                cmd.cap_minmax = 1'b1;
                state_next     = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_mean = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

@@ hdl/frame_time_window_stats.sv @@
// top level: register port, result register, controller and datapath
// begin, clear and ignored events go through the execute and finish states
// end events run serial 64-step divisions, one at a time, in one shared divider:
// one to four divisions (two more on a period hit), plus a scan over the window entries
// one event at a time; the next is taken the cycle after the result register is loaded
// reset: metrics, window and period counters zero, enable 1, display period 1000000 us
`default_nettype none
module frame_time_window_stats #(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ftws_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    ftws_in_if.sink                         in_ch,
    ftws_out_if.source                      out_ch
);
    import ftws_pkg::*;

    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    logic          enable_reg;
    logic [31:0]   period_reg;
    logic          out_valid_reg;
    ftws_metrics_t out_met_reg;
    logic [FW-1:0] out_fill_reg;

    ftws_cmd_t     cmd;
    ftws_sts_t     sts;
    ftws_metrics_t metrics;
    logic [FW-1:0] fill;
    logic          out_free;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            period_reg <= PERIOD_RESET;
        end
        else if (wr_en)
        begin
            if (paddr == ADDR_ENABLE)
            begin
                enable_reg <= pwdata[0];
            end
            else if (paddr == ADDR_PERIOD)
            begin
                period_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_ENABLE: prdata = {31'd0, enable_reg};
            ADDR_PERIOD: prdata = period_reg;
            default:     prdata = '0;
        endcase
    end

    ftws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftws_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FW            (FW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_mode         (in_ch.mode),
        .in_timestamp_us (in_ch.timestamp_us),
        .cfg_enable      (enable_reg),
        .cfg_period_us   (period_reg),
        .metrics         (metrics),
        .window_fill     (fill)
    );

    // result register
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_met_reg  <= metrics;
            out_fill_reg <= fill;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.frame_time_us  = out_met_reg.frame_time_us;
    assign out_ch.fps_q8         = out_met_reg.fps_q8;
    assign out_ch.window_min_us  = out_met_reg.window_min_us;
    assign out_ch.window_max_us  = out_met_reg.window_max_us;
    assign out_ch.window_mean_us = out_met_reg.window_mean_us;
    assign out_ch.period_fps_q8  = out_met_reg.period_fps_q8;
    assign out_ch.period_mean_us = out_met_reg.period_mean_us;
    assign out_ch.frame_total    = out_met_reg.frame_total;
    assign out_ch.window_fill    = out_fill_reg;
endmodule
`default_nettype wire
